[design/ess_pkg.sv]
// ----------------------------------------------------------------------------
// ess_pkg
// Shared types and constants for the embedding similarity scorer.
// ----------------------------------------------------------------------------
package ess_pkg;

	localparam int ESS_MAX_DIM = 1024;

	// score kinds held in the metric register
	localparam logic [1:0] METRIC_L2  = 2'd0;
	localparam logic [1:0] METRIC_COS = 2'd1;
	localparam logic [1:0] METRIC_DOT = 2'd2;

	localparam int ACC_W  = 48;
	localparam int SCORE_W = 32;

	// iteration counts of the shared sqrt / divide datapath
	localparam logic [6:0] SQRT_LAST = 7'd31;  // 32 digit pairs of a 64-bit radicand
	localparam logic [6:0] DIV_LAST  = 7'd80;  // 48 numerator bits plus 33 fraction bits

	localparam logic [31:0] L2_MIN_SCORE = 32'd7;
	localparam logic [31:0] Q1616_ONE    = 32'd65536;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_SD,
		ST_MUL_SS,
		ST_MUL_DD,
		ST_ACC,
		ST_FIN,
		ST_L2_SQRT,
		ST_L2_RND,
		ST_NS_SQRT,
		ST_ND_SQRT,
		ST_P_MUL,
		ST_DIV,
		ST_COS_RND,
		ST_DONE
	} ess_state_t;

endpackage

[design/embedding_similarity_score.sv]
// ----------------------------------------------------------------------------
// embedding_similarity_score
// Accumulates dot product and sums of squares of two embeddings and
// emits an L2, cosine or dot score in saturating Q16.16.
// ----------------------------------------------------------------------------
//  channel   | signals                                  | direction
//  ----------+------------------------------------------+----------
//  pair      | pair_valid pair_stall src_value          | in
//            | dst_value last_pair                      |
//  score     | score_valid score_stall score            | out
//  cfg       | cfg_we cfg_wdata (metric)                | in
//
// per pair beat one 32x32 multiplier forms s*d, s*s and d*d in MUL_SD,
// MUL_SS and MUL_DD; the three sums add them in MUL_SS, MUL_DD and ACC
// on the last pair the finish runs: L2 a 32-step sqrt on the shared
// subtract unit, cosine two sqrts, one multiply and an 81-step divide
// (none on a zero norm), dot or unused metric straight to ST_DONE
// pair_stall is high whenever the sequencer is busy; a waiting score
// sits in the output register while the next vector streams in
// reset clears the accumulators and the metric register (L2)
module embedding_similarity_score
	import ess_pkg::*;
#(
	parameter int MAX_DIM = ESS_MAX_DIM
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_wdata,
	input  logic               pair_valid,
	output logic               pair_stall,
	input  logic signed [15:0] src_value,
	input  logic signed [15:0] dst_value,
	input  logic               last_pair,
	output logic               score_valid,
	input  logic               score_stall,
	output logic signed [31:0] score
);

	localparam int CNT_W = $clog2(MAX_DIM + 1);

	ess_state_t state_q, state_d;

	logic [1:0]               metric_q;
	logic [CNT_W-1:0]         cnt_q;
	logic signed [ACC_W-1:0]  dot_q;
	logic signed [ACC_W-1:0]  src_sq_q;
	logic signed [ACC_W-1:0]  dst_sq_q;
	logic                     score_valid_q;

	logic signed [15:0]       src_q;
	logic signed [15:0]       dst_q;
	logic                     last_q;
	logic signed [63:0]       prod_q;
	logic [63:0]              rad_q;
	logic [63:0]              rem_q;
	logic [31:0]              root_q;
	logic [30:0]              ns_q;
	logic [ACC_W-1:0]         num_q;
	logic [6:0]               step_q;
	logic signed [31:0]       res_q;
	logic signed [31:0]       score_q;

	logic                     pair_acc;
	logic                     acc_en;
	logic                     out_free;
	logic                     zero_norm;
	logic                     step_last;

	// shared multiplier
	logic signed [31:0]       mul_a, mul_b;
	logic signed [63:0]       mul_p;

	// shared compare / subtract unit
	logic [63:0]              sub_a, sub_b;
	logic [64:0]              sub_diff;
	logic                     sub_ge;

	logic signed [49:0]       l2_d;
	logic [63:0]              l2_rad;
	logic signed [48:0]       dot_rnd;
	logic signed [40:0]       dot_q41;
	logic signed [31:0]       dot_score;
	logic [ACC_W-1:0]         dot_abs;
	logic [31:0]              l2_r;
	logic [31:0]              l2_score;
	logic [32:0]              cos_half;
	logic [31:0]              cos_cap;
	logic signed [31:0]       cos_score;

	assign pair_acc  = pair_valid && !pair_stall;
	assign acc_en    = cnt_q < CNT_W'(MAX_DIM);
	assign out_free  = !score_valid_q || !score_stall;
	assign zero_norm = (src_sq_q == '0) || (dst_sq_q == '0);
	assign step_last = (state_q == ST_DIV) ? (step_q == DIV_LAST) : (step_q == SQRT_LAST);

	assign score_valid = score_valid_q;
	assign score       = score_q;

	always_comb begin
		mul_a = {{16{src_q[15]}}, src_q};
		mul_b = {{16{dst_q[15]}}, dst_q};
		unique case (state_q)
			ST_MUL_SS: begin
				mul_b = {{16{src_q[15]}}, src_q};
			end
			ST_MUL_DD: begin
				mul_a = {{16{dst_q[15]}}, dst_q};
			end
			ST_P_MUL: begin
				mul_a = {1'b0, ns_q};
				mul_b = {1'b0, root_q[30:0]};
			end
			default: begin
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	always_comb begin
		if (state_q == ST_DIV) begin
			sub_a = {rem_q[62:0], num_q[ACC_W-1]};
			sub_b = prod_q;
		end else begin
			sub_a = {rem_q[61:0], rad_q[63:62]};
			sub_b = {30'd0, root_q, 2'b01};
		end
	end
	assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
	assign sub_ge   = !sub_diff[64];

	// L2 radicand (|s|^2 + |d|^2 - 2 s.d) << 8, clamped at zero
	assign l2_d   = {2'b00, src_sq_q} + {2'b00, dst_sq_q} - {dot_q[ACC_W-1], dot_q, 1'b0};
	assign l2_rad = l2_d[49] ? 64'd0 : {6'd0, l2_d[49:0], 8'd0};

	// dot: round half up then saturate to int32
	assign dot_rnd = {dot_q[ACC_W-1], dot_q} + 49'sd128;
	assign dot_q41 = dot_rnd[48:8];
	always_comb begin
		if (dot_q41[40:31] == {10{dot_q41[31]}}) begin
			dot_score = dot_q41[31:0];
		end else if (dot_q41[40]) begin
			dot_score = 32'sh8000_0000;
		end else begin
			dot_score = 32'sh7fff_ffff;
		end
	end

	assign dot_abs = dot_q[ACC_W-1] ? ACC_W'(-dot_q) : dot_q;

	// L2 round to nearest: remainder past root means the next integer is closer
	assign l2_r     = root_q + 32'(rem_q > {32'd0, root_q});
	assign l2_score = (l2_r < L2_MIN_SCORE) ? L2_MIN_SCORE : l2_r;

	assign cos_half  = ({1'b0, root_q} + 33'd1) >> 1;
	assign cos_cap   = (cos_half > {1'b0, Q1616_ONE}) ? Q1616_ONE : cos_half[31:0];
	always_comb begin
		if (prod_q == '0) begin
			cos_score = '0;
		end else if (dot_q[ACC_W-1]) begin
			cos_score = -$signed(cos_cap);
		end else begin
			cos_score = $signed(cos_cap);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (pair_valid) state_d = ST_MUL_SD;
			end
			ST_MUL_SD: state_d = ST_MUL_SS;
			ST_MUL_SS: state_d = ST_MUL_DD;
			ST_MUL_DD: state_d = ST_ACC;
			ST_ACC: begin
				state_d = last_q ? ST_FIN : ST_IDLE;
			end
			ST_FIN: begin
				case (metric_q)
					METRIC_L2:  state_d = ST_L2_SQRT;
					METRIC_COS: state_d = zero_norm ? ST_DONE : ST_NS_SQRT;
					default:    state_d = ST_DONE;
				endcase
			end
			ST_L2_SQRT: begin
				if (step_last) state_d = ST_L2_RND;
			end
			ST_L2_RND: state_d = ST_DONE;
			ST_NS_SQRT: begin
				if (step_last) state_d = ST_ND_SQRT;
			end
			ST_ND_SQRT: begin
				if (step_last) state_d = ST_P_MUL;
			end
			ST_P_MUL: state_d = ST_DIV;
			ST_DIV: begin
				if (step_last) state_d = ST_COS_RND;
			end
			ST_COS_RND: state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		unique case (state_q)
			ST_IDLE: pair_stall = 1'b0;
			default: pair_stall = 1'b1;
		endcase
	end

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			metric_q      <= METRIC_L2;
			cnt_q         <= '0;
			dot_q         <= '0;
			src_sq_q      <= '0;
			dst_sq_q      <= '0;
			score_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) metric_q <= cfg_wdata;
			if (state_q == ST_DONE && out_free) begin
				score_valid_q <= 1'b1;
			end else if (score_valid_q && !score_stall) begin
				score_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_MUL_SS: begin
					if (acc_en) dot_q <= dot_q + prod_q[ACC_W-1:0];
				end
				ST_MUL_DD: begin
					if (acc_en) src_sq_q <= src_sq_q + prod_q[ACC_W-1:0];
				end
				ST_ACC: begin
					if (acc_en) begin
						dst_sq_q <= dst_sq_q + prod_q[ACC_W-1:0];
						cnt_q    <= cnt_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						cnt_q         <= '0;
						dot_q         <= '0;
						src_sq_q      <= '0;
						dst_sq_q      <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (pair_acc) begin
			src_q  <= src_value;
			dst_q  <= dst_value;
			last_q <= last_pair;
		end
		unique case (state_q) inside
			ST_MUL_SD, ST_MUL_SS, ST_MUL_DD: begin
				prod_q <= mul_p;
			end
			ST_FIN: begin
				rem_q  <= '0;
				root_q <= '0;
				step_q <= '0;
				rad_q  <= (metric_q == METRIC_L2) ? l2_rad : {src_sq_q, 16'd0};
				case (metric_q)
					METRIC_DOT: res_q <= dot_score;
					default:    res_q <= '0;
				endcase
			end
			ST_L2_SQRT, ST_NS_SQRT, ST_ND_SQRT: begin
				if (state_q == ST_NS_SQRT && step_last) begin
					// source norm done, start on the destination norm
					ns_q   <= {root_q[29:0], sub_ge};
					rem_q  <= '0;
					root_q <= '0;
					step_q <= '0;
					rad_q  <= {dst_sq_q, 16'd0};
				end else begin
					rem_q  <= sub_ge ? sub_diff[63:0] : sub_a;
					root_q <= {root_q[30:0], sub_ge};
					rad_q  <= {rad_q[61:0], 2'b00};
					step_q <= step_q + 7'd1;
				end
			end
			ST_L2_RND: begin
				res_q <= $signed(l2_score);
			end
			ST_P_MUL: begin
				prod_q <= mul_p;
				rem_q  <= '0;
				root_q <= '0;
				step_q <= '0;
				num_q  <= dot_abs;
			end
			ST_DIV: begin
				// quotient bits shift into the root register
				rem_q  <= sub_ge ? sub_diff[63:0] : sub_a;
				root_q <= {root_q[30:0], sub_ge};
				num_q  <= {num_q[ACC_W-2:0], 1'b0};
				step_q <= step_q + 7'd1;
			end
			ST_COS_RND: begin
				res_q <= cos_score;
			end
			ST_DONE: begin
				if (out_free) score_q <= res_q;
			end
			default: begin
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	// a score beat only appears out of the load state
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(score_valid_q) |-> $past(state_q == ST_DONE))
		else $error("score raised outside load state");

	// a fresh vector starts from cleared sums
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && cnt_q == '0) |->
		(dot_q == '0 && src_sq_q == '0 && dst_sq_q == '0))
		else $error("accumulators not cleared at vector start");

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_DIM))
		else $error("pair count beyond vector limit");

	assert property (@(posedge clk) disable iff (!arst_n)
		!src_sq_q[ACC_W-1] && !dst_sq_q[ACC_W-1])
		else $error("sum of squares went negative");

	// the output register is never overwritten while a beat is stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		(score_valid_q && score_stall) |=> $stable(score_q))
		else $error("stalled score overwritten");
`endif

endmodule

[bench/ess_checker.sv]
// ----------------------------------------------------------------------------
// ess_checker
// Watches the pair, score and register ports of the similarity scorer.
// Keeps its own accumulators and metric copy, predicts one score per
// vector and compares each accepted score beat with the oldest prediction.
// ----------------------------------------------------------------------------
module ess_checker
	import ess_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_wdata,
	input  logic               pair_valid,
	input  logic               pair_stall,
	input  logic signed [15:0] src_value,
	input  logic signed [15:0] dst_value,
	input  logic               last_pair,
	input  logic               score_valid,
	input  logic               score_stall,
	input  logic signed [31:0] score,
	output int unsigned        fail_count,
	output int unsigned        scores_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [1:0]         metric_copy;
	longint             dot_acc;
	longint             src_sq_acc;
	longint             dst_sq_acc;
	int unsigned        pairs_in_vector;
	int unsigned        mismatch_total;
	logic signed [31:0] score_fifo[$];
	logic signed [31:0] oldest_score;

	function automatic longint unsigned root_floor(input longint unsigned x);
		longint unsigned res;
		longint unsigned bit_w;
		longint unsigned rest;
		res = 0;
		rest = x;
		bit_w = 64'd1 << 62;
		while (bit_w > rest)
			bit_w >>= 2;
		while (bit_w != 0) begin
			if (rest >= res + bit_w) begin
				rest -= res + bit_w;
				res = (res >> 1) + bit_w;
			end else begin
				res >>= 1;
			end
			bit_w >>= 2;
		end
		return res;
	endfunction

	function automatic logic signed [31:0] clamp_q1616(input longint v);
		if (v > 64'sd2147483647)
			return 32'sh7FFF_FFFF;
		if (v < -64'sd2147483648)
			return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] l2_distance(input longint dot, input longint ss,
			input longint dd);
		longint          diff;
		longint unsigned x;
		longint unsigned r;
		diff = ss + dd - 2 * dot;
		if (diff < 0)
			diff = 0;
		x = $unsigned(diff) << 8;
		r = root_floor(x);
		// round to nearest
		if (x - r * r > r)
			r++;
		if (r < L2_MIN_SCORE)
			r = L2_MIN_SCORE;
		return clamp_q1616($signed(r));
	endfunction

	function automatic logic signed [31:0] cosine_similarity(input longint dot, input longint ss,
			input longint dd);
		longint unsigned norm_s;
		longint unsigned norm_d;
		longint unsigned p;
		longint unsigned a;
		longint unsigned q;
		longint unsigned rem;
		longint          mag;
		int              i;
		if (ss <= 0 || dd <= 0)
			return 0;
		norm_s = root_floor($unsigned(ss) << 16);
		norm_d = root_floor($unsigned(dd) << 16);
		p = norm_s * norm_d;
		if (p == 0)
			return 0;
		mag = (dot < 0) ? -dot : dot;
		a = $unsigned(mag) << 16;
		q = a / p;
		rem = a % p;
		// 16 fraction bits plus one rounding bit
		for (i = 0; i < 17; i++) begin
			rem <<= 1;
			q <<= 1;
			if (rem >= p) begin
				rem -= p;
				q++;
			end
		end
		q = (q + 1) >> 1;
		if (q > Q1616_ONE)
			q = Q1616_ONE;
		return (dot < 0) ? -$signed(q[31:0]) : $signed(q[31:0]);
	endfunction

	function automatic logic signed [31:0] dot_product(input longint dot);
		longint x;
		// arithmetic shift floors, so ties go toward +inf
		x = dot + 128;
		return clamp_q1616(x >>> 8);
	endfunction

	function automatic logic signed [31:0] predict_score(input logic [1:0] m, input longint dot,
			input longint ss, input longint dd);
		case (m)
			METRIC_L2:  return l2_distance(dot, ss, dd);
			METRIC_COS: return cosine_similarity(dot, ss, dd);
			METRIC_DOT: return dot_product(dot);
			default:    return 0;
		endcase
	endfunction

	task automatic report(input string what, input logic signed [31:0] got,
			input logic signed [31:0] want);
		if (mismatch_total < 100)
			$display("%0t ess_checker: %s: got %0d want %0d", $time, what, got, want);
		mismatch_total++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			metric_copy = METRIC_L2;
			dot_acc = 0;
			src_sq_acc = 0;
			dst_sq_acc = 0;
			pairs_in_vector = 0;
			mismatch_total = 0;
			score_fifo.delete();
			fail_count <= 0;
			scores_pending <= 0;
		end else begin
			if (cfg_we)
				metric_copy = cfg_wdata;
			if (pair_valid && !pair_stall) begin
				// pairs past the dimension limit are dropped
				if (pairs_in_vector < ESS_MAX_DIM) begin
					dot_acc += longint'(src_value) * longint'(dst_value);
					src_sq_acc += longint'(src_value) * longint'(src_value);
					dst_sq_acc += longint'(dst_value) * longint'(dst_value);
					pairs_in_vector++;
				end
				if (last_pair) begin
					score_fifo.push_back(predict_score(metric_copy, dot_acc, src_sq_acc,
						dst_sq_acc));
					dot_acc = 0;
					src_sq_acc = 0;
					dst_sq_acc = 0;
					pairs_in_vector = 0;
				end
			end
			if (score_valid && !score_stall) begin
				if (score_fifo.size() == 0) begin
					report("score beat with nothing expected", score, '0);
				end else begin
					oldest_score = score_fifo.pop_front();
					if (score !== oldest_score)
						report("score mismatch", score, oldest_score);
				end
			end
			fail_count <= mismatch_total;
			scores_pending <= score_fifo.size();
		end
	end

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the embedding similarity scorer. Streams directed
// and random element pairs under all metric settings with random gaps on
// both channels, a long output hold, dot saturation and an over-long vector.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import ess_pkg::*;

	localparam logic [1:0] METRIC_NONE = 2'd3;
	localparam int MAX_GAP        = 11;
	localparam int SETTLE_CYCLES  = 200;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_PAIRS   = 150;
	localparam int NEG_SAT_PAIRS  = 514;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [1:0]         cfg_wdata = '0;
	logic               pair_valid = 1'b0;
	logic               pair_stall;
	logic signed [15:0] src_value = '0;
	logic signed [15:0] dst_value = '0;
	logic               last_pair = 1'b0;
	logic               score_valid;
	logic               score_stall = 1'b0;
	logic signed [31:0] score;

	int unsigned fail_count;
	int unsigned pending;

	bit          send_idle_on = 1'b1;
	bit          recv_idle_on = 1'b1;
	bit          hold_request = 1'b0;
	logic [1:0]  cur_metric = METRIC_L2;
	int unsigned pairs_sent = 0;
	int unsigned vectors_by_metric[4] = '{0, 0, 0, 0};
	int unsigned quiet_cycles = 0;

	embedding_similarity_score dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.pair_valid (pair_valid),
		.pair_stall (pair_stall),
		.src_value  (src_value),
		.dst_value  (dst_value),
		.last_pair  (last_pair),
		.score_valid(score_valid),
		.score_stall(score_stall),
		.score      (score)
	);

	ess_checker score_watch (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.pair_valid    (pair_valid),
		.pair_stall    (pair_stall),
		.src_value     (src_value),
		.dst_value     (dst_value),
		.last_pair     (last_pair),
		.score_valid   (score_valid),
		.score_stall   (score_stall),
		.score         (score),
		.fail_count    (fail_count),
		.scores_pending(pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((pair_valid && !pair_stall) || (score_valid && !score_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_top: watchdog, no beat for %0d cycles", quiet_cycles);
				$display("tb_top: errors");
				$finish;
			end
		end
	end

	// score receiver: random stall per beat, one long hold on request
	initial begin : score_receiver
		int unsigned stall_len;
		forever begin
			stall_len = recv_idle_on ? $urandom_range(0, MAX_GAP) : 0;
			if (hold_request) begin
				hold_request = 1'b0;
				stall_len = HOLD_CYCLES;
			end
			if (stall_len > 0) begin
				score_stall <= 1'b1;
				repeat (stall_len) @(posedge clk);
			end
			score_stall <= 1'b0;
			do @(posedge clk); while (!(score_valid && !score_stall));
		end
	end

	function automatic int extreme_element();
		case ($urandom_range(0, 5))
			0:       return -32768;
			1:       return -32767;
			2:       return -1;
			3:       return 0;
			4:       return 1;
			default: return 32767;
		endcase
	endfunction

	function automatic int pick_element();
		case ($urandom_range(0, 3))
			0:       return $urandom_range(0, 65535);
			1:       return int'($urandom_range(0, 127)) - 64;
			2:       return extreme_element();
			default: return int'($urandom_range(0, 8191)) - 4096;
		endcase
	endfunction

	task automatic send_pair(input int s, input int d, input bit last);
		int unsigned gap;
		gap = send_idle_on ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			pair_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pair_valid <= 1'b1;
		src_value <= s[15:0];
		dst_value <= d[15:0];
		last_pair <= last;
		do @(posedge clk); while (pair_stall);
		pairs_sent++;
		if (last)
			vectors_by_metric[cur_metric]++;
	endtask

	// register writes only once the block has drained
	task automatic set_metric(input logic [1:0] m);
		pair_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_metric = m;
	endtask

	task automatic send_vector(input int len);
		int style;
		int s;
		int d;
		int i;
		style = $urandom_range(0, 4);
		for (i = 0; i < len; i++) begin
			s = pick_element();
			case (style)
				0:       d = pick_element();
				1:       d = s;
				2:       d = -s;
				3:       d = s + int'($urandom_range(0, 64)) - 32;
				default: d = extreme_element();
			endcase
			send_pair(s, d, i == len - 1);
		end
	endtask

	task automatic send_fill(input int len, input int s, input int d);
		int i;
		for (i = 0; i < len; i++)
			send_pair(s, d, i == len - 1);
	endtask

	initial begin : stimulus
		int unsigned random_start;
		int          phase;
		int          i;
		logic [1:0]  m;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// l2: zero distance hits the floor, widest distance, two-pair vector
		set_metric(METRIC_L2);
		send_pair(0, 0, 1);
		send_pair(32767, -32768, 1);
		send_pair(100, -50, 0);
		send_pair(-4096, 4096, 1);

		// cosine: zero norm, opposite extremes, orthogonal pair
		set_metric(METRIC_COS);
		send_pair(0, 1234, 1);
		send_pair(-32768, 32767, 1);
		send_pair(4096, 0, 0);
		send_pair(0, 4096, 1);

		// dot: rounding ties both signs, largest single product
		set_metric(METRIC_DOT);
		send_pair(1, 128, 1);
		send_pair(-1, 128, 1);
		send_pair(1, -129, 1);
		send_pair(-32768, -32768, 1);

		// selector value with no meaning
		set_metric(METRIC_NONE);
		send_pair(12345, -2222, 1);

		random_start = pairs_sent;
		phase = 0;
		while (phase < 4 || pairs_sent - random_start < RANDOM_PAIRS) begin
			m = (phase < 4) ? phase[1:0] : 2'($urandom_range(0, 3));
			set_metric(m);
			send_idle_on = ($urandom_range(0, 3) != 0);
			recv_idle_on = ($urandom_range(0, 3) != 0);
			if (phase == 2) begin
				// receiver holds while beats keep coming, so the block backs up
				send_idle_on = 1'b0;
				hold_request = 1'b1;
			end
			repeat ($urandom_range(4, 12))
				send_vector(($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
					: $urandom_range(1, 8));
			phase++;
		end

		// dot saturation upward
		set_metric(METRIC_DOT);
		send_idle_on = 1'b0;
		send_fill(512, -32768, -32768);

		// dot saturation downward in an over-long vector: the closing pairs
		// past the dimension limit would pull the sum back into range if counted
		send_idle_on = 1'b1;
		for (i = 0; i < ESS_MAX_DIM + 6; i++) begin
			if (i < NEG_SAT_PAIRS)
				send_pair(32767, -32768, 1'b0);
			else if (i < ESS_MAX_DIM)
				send_pair(int'($urandom_range(0, 127)) - 64, int'($urandom_range(0, 127)) - 64,
					1'b0);
			else
				send_pair(32767, 32767, i == ESS_MAX_DIM + 5);
		end

		pair_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("run: %0d pairs; vectors per metric l2 %0d, cosine %0d, dot %0d, unused %0d",
			pairs_sent, vectors_by_metric[0], vectors_by_metric[1], vectors_by_metric[2],
			vectors_by_metric[3]);
		$display("run: random gaps on both sides, a %0d-cycle output hold, dot saturation, %0s",
			HOLD_CYCLES, "one vector past the dimension limit");
		if (fail_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
